/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that b holds in the cycle after a, ignored while reset is asserted.
`define TFBC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("tfbc assertion failed");

// Checks that b holds in the cycle after a, evaluated through reset as well.
`define TFBC_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("tfbc assertion failed");

`endif

/* rtl/tfbc_pkg.sv */
// Package with the shared constants and types of the table feedback bit converter.
`timescale 1ns / 1ps

package tfbc_pkg;

  localparam int MAX_DIM_DEF = 10;
  localparam int DIM_W       = 4;
  localparam int ENTRY_ROW_W = 10;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd10;

  typedef enum logic {
    ACT_CONVERT = 1'b0,
    ACT_WRITE   = 1'b1
  } action_t;

  // Request from the converter to the table memories for one cycle.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_col;
    logic wr_val;
  } tbl_ctrl_t;

endpackage

/* rtl/tfbc_table.sv */
// Two single-bit table memories, one per column, with the clearing sweep after reset.
`timescale 1ns / 1ps

module tfbc_table #(
  parameter int MAX_DIM = tfbc_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfbc_pkg::tbl_ctrl_t ctrl,
  input  logic [MAX_DIM-1:0]  addr,
  output logic [1:0]          rd_data,
  output logic                clearing
);

  localparam int ROWS = 1 << MAX_DIM;

  logic mem0 [ROWS];
  logic mem1 [ROWS];

  logic               clr_active_r;
  logic [MAX_DIM-1:0] clr_idx_r;
  logic [1:0]         rd_data_r;

  // The sweep loads the default pattern, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= clr_idx_r + MAX_DIM'(1);
      if (clr_idx_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem0[clr_idx_r] <= ~(^clr_idx_r);
      mem1[clr_idx_r] <= ^clr_idx_r;
    end else if (ctrl.wr_en) begin
      if (ctrl.wr_col) begin
        mem1[addr] <= ctrl.wr_val;
      end else begin
        mem0[addr] <= ctrl.wr_val;
      end
    end
    if (ctrl.rd_en) begin
      rd_data_r <= {mem1[addr], mem0[addr]};
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

/* rtl/tfbc_conv.sv */
// Conversion control: dimension register, history, lookup interlock and output register.
`timescale 1ns / 1ps

module tfbc_conv #(
  parameter int MAX_DIM = tfbc_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tfbc_pkg::DIM_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic                               in_first,
  input  logic                               in_bit,
  input  logic [tfbc_pkg::ENTRY_ROW_W-1:0]   in_entry_row,
  input  logic                               in_entry_column,
  input  logic                               in_entry_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_bit,
  output tfbc_pkg::tbl_ctrl_t                tbl_ctrl,
  output logic [MAX_DIM-1:0]                 tbl_addr,
  input  logic [1:0]                         tbl_rd_data,
  input  logic                               tbl_clearing
);

  logic [tfbc_pkg::DIM_W-1:0] dim_r;
  logic [MAX_DIM-1:0]         mask;
  logic [MAX_DIM-1:0]         history_r, history_nxt;
  logic [MAX_DIM-1:0]         row_r;
  logic [MAX_DIM-1:0]         rd_row;
  logic                       col_r;
  logic                       busy_r, busy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_bit_r;
  logic                       accept, is_write, sel_bit, done;

  // Row mask of the active dimension; values above the table width saturate.
  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      mask[i] = (dim_r > tfbc_pkg::DIM_W'(i));
    end
  end

  assign in_ready = !tbl_clearing && !busy_r;
  assign accept   = in_valid && in_ready;
  assign is_write = (in_action == tfbc_pkg::ACT_WRITE);
  assign rd_row   = (in_first ? '0 : history_r) & mask;

  always_comb begin
    tbl_ctrl.rd_en  = accept && !is_write;
    tbl_ctrl.wr_en  = accept && is_write;
    tbl_ctrl.wr_col = in_entry_column;
    tbl_ctrl.wr_val = in_entry_value;
    tbl_addr        = is_write ? MAX_DIM'(in_entry_row) : rd_row;
  end

  assign sel_bit = col_r ? tbl_rd_data[1] : tbl_rd_data[0];
  assign done    = busy_r && (!out_valid_r || out_ready);

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    history_nxt   = history_r;
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      history_nxt   = ((row_r << 1) | MAX_DIM'(sel_bit)) & mask;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_nxt = 1'b0;
      end
      if (tbl_ctrl.rd_en) begin
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r       <= tfbc_pkg::DIM_RESET;
      history_r   <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dim_r <= cfg_wr_data;
      end
      history_r   <= history_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_ctrl.rd_en) begin
      row_r <= rd_row;
      col_r <= in_bit;
    end
    if (done) begin
      out_bit_r <= sel_bit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;

endmodule

/* rtl/table_feedback_bit_converter_core.sv */
// Top level of the table feedback bit converter.
// Input transactions carry an action: a convert looks up the table at the row given by
// the history of recent output bits and the column given by in_bit, returns that bit on
// the output channel and shifts it into the history; in_first clears the history first.
// A write transaction stores in_entry_value at one table entry and gives no result.
// cfg_wr_data sets the dimension, the number of history bits that index the table; the
// user must write it only while the block is idle (the block does not enforce this), and
// values above MAX_DIM act as MAX_DIM. The table read issued at acceptance is registered
// in the table, and the next row depends on that bit, so no further input is taken until
// that bit has moved into the output register and history. Write transactions are taken
// on every cycle while no convert is pending and the sweep has finished.
// After reset the table is loaded with its default pattern, one row per cycle over all
// 2**MAX_DIM rows (1024 by default); in_ready stays low meanwhile, while configuration
// writes are still taken.
// When the receiver stalls, the result is held in the output register and one further
// convert may be accepted; its table bit is read at once but is held, with in_ready low,
// until the register drains, and only then does it move into the register and history.
`timescale 1ns / 1ps

module table_feedback_bit_converter_core #(
  parameter int MAX_DIM = tfbc_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tfbc_pkg::DIM_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic                             in_first,
  input  logic                             in_bit,
  input  logic [tfbc_pkg::ENTRY_ROW_W-1:0] in_entry_row,
  input  logic                             in_entry_column,
  input  logic                             in_entry_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_bit
);

  // Read and write share one row address: a transaction either reads or writes.
  tfbc_pkg::tbl_ctrl_t tbl_ctrl;
  logic [MAX_DIM-1:0]  tbl_addr;
  logic [1:0]          tbl_rd_data;
  logic                tbl_clearing;

  tfbc_conv #(
    .MAX_DIM(MAX_DIM)
  ) u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_first        (in_first),
    .in_bit          (in_bit),
    .in_entry_row    (in_entry_row),
    .in_entry_column (in_entry_column),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit         (out_bit),
    .tbl_ctrl        (tbl_ctrl),
    .tbl_addr        (tbl_addr),
    .tbl_rd_data     (tbl_rd_data),
    .tbl_clearing    (tbl_clearing)
  );

  // Both table columns, with the default pattern loaded by a sweep after reset.
  tfbc_table #(
    .MAX_DIM(MAX_DIM)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (tbl_ctrl),
    .addr     (tbl_addr),
    .rd_data  (tbl_rd_data),
    .clearing (tbl_clearing)
  );

endmodule

/* rtl/tfbc_checker.sv */
// Port-level checker of the converter, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit
);

  `TFBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bit))
  `TFBC_ASSERT_NEXT_ALWAYS(a_sweep_after_reset, clk, !rst_n, !in_ready)
  `TFBC_ASSERT_NEXT(a_convert_interlock, clk, rst_n, in_valid && in_ready && !in_action, !in_ready)
  `TFBC_ASSERT_NEXT(a_write_no_result, clk, rst_n, in_valid && in_ready && in_action && !out_valid, !out_valid)

endmodule

bind table_feedback_bit_converter_core tfbc_checker u_tfbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_bit   (out_bit)
);
